// ----- rtl/rvalu_pkg.sv -----
// Shared types, constants and command codes of the RV32I integer execution unit.
`timescale 1ns / 1ps

package rvalu_pkg;

  localparam int XLEN           = 32;
  localparam int TAG_BITS       = 6;
  localparam int LATENCY_BITS   = 4;
  localparam int CMD_BITS       = 4;
  localparam int SHAMT_BITS     = 5;
  localparam int NUM_LAT_REGS   = 7;
  localparam int CFG_INDEX_BITS = 3;

  localparam int IN_FIELD_BITS  = 1 + 3 * XLEN + TAG_BITS + 1;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_PAD_BITS    = IN_TDATA_BITS - IN_FIELD_BITS;
  localparam int OUT_FIELD_BITS = 2 + TAG_BITS + XLEN + 1;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_LUI   = 4'd2,
    CMD_AUIPC = 4'd3,
    CMD_SLL   = 4'd4,
    CMD_SLT   = 4'd5,
    CMD_SLTU  = 4'd6,
    CMD_XOR   = 4'd7,
    CMD_SRL   = 4'd8,
    CMD_SRA   = 4'd9,
    CMD_OR    = 4'd10,
    CMD_AND   = 4'd11
  } command_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CLASS_ADD     = 3'd0,
    CLASS_SUB     = 3'd1,
    CLASS_LUI     = 3'd2,
    CLASS_AUIPC   = 3'd3,
    CLASS_SHIFT   = 3'd4,
    CLASS_COMPARE = 3'd5,
    CLASS_LOGIC   = 3'd6
  } lat_class_t;

  typedef struct packed {
    logic                issue_valid;
    logic [CMD_BITS-1:0] command;
    logic [XLEN-1:0]     operand_a;
    logic [XLEN-1:0]     operand_b;
    logic [XLEN-1:0]     inst_pc;
    logic [TAG_BITS-1:0] rob_tag;
    logic                flush;
  } issue_item_t;

  typedef struct packed {
    logic                accepted;
    logic                result_valid;
    logic [TAG_BITS-1:0] result_tag;
    logic [XLEN-1:0]     result_value;
    logic                bad_command;
  } result_item_t;

  typedef struct packed {
    logic [XLEN-1:0] value;
    lat_class_t      lat_class;
    logic            bad_command;
  } alu_out_t;

endpackage

// ----- rtl/rvalu_alu.sv -----
// Combinational RV32I integer datapath: result value and latency class of one command.
`timescale 1ns / 1ps

module rvalu_alu
  import rvalu_pkg::*;
(
  input  logic [CMD_BITS-1:0] command,
  input  logic [XLEN-1:0]     operand_a,
  input  logic [XLEN-1:0]     operand_b,
  input  logic [XLEN-1:0]     inst_pc,
  output alu_out_t            alu_out
);

  logic                  is_sub;
  logic [XLEN-1:0]       add_rhs;
  logic [XLEN-1:0]       add_sum;
  logic [SHAMT_BITS-1:0] shamt;
  logic                  lt_signed;
  logic                  lt_unsigned;

  // One adder serves add, sub and auipc.
  assign is_sub  = (command == CMD_SUB);
  assign add_rhs = (command == CMD_AUIPC) ? inst_pc : (is_sub ? ~operand_b : operand_b);
  assign add_sum = operand_a + add_rhs + {{(XLEN-1){1'b0}}, is_sub};

  assign shamt       = operand_b[SHAMT_BITS-1:0];
  assign lt_signed   = ($signed(operand_a) < $signed(operand_b));
  assign lt_unsigned = (operand_a < operand_b);

  always_comb begin
    alu_out.value       = '0;
    alu_out.lat_class   = CLASS_ADD;
    alu_out.bad_command = 1'b0;
    case (command)
      CMD_ADD: begin
        alu_out.value     = add_sum;
        alu_out.lat_class = CLASS_ADD;
      end
      CMD_SUB: begin
        alu_out.value     = add_sum;
        alu_out.lat_class = CLASS_SUB;
      end
      CMD_LUI: begin
        alu_out.value     = operand_a;
        alu_out.lat_class = CLASS_LUI;
      end
      CMD_AUIPC: begin
        alu_out.value     = add_sum;
        alu_out.lat_class = CLASS_AUIPC;
      end
      CMD_SLL: begin
        alu_out.value     = operand_a << shamt;
        alu_out.lat_class = CLASS_SHIFT;
      end
      CMD_SRL: begin
        alu_out.value     = operand_a >> shamt;
        alu_out.lat_class = CLASS_SHIFT;
      end
      CMD_SRA: begin
        alu_out.value     = $unsigned($signed(operand_a) >>> shamt);
        alu_out.lat_class = CLASS_SHIFT;
      end
      CMD_SLT: begin
        alu_out.value     = {{(XLEN-1){1'b0}}, lt_signed};
        alu_out.lat_class = CLASS_COMPARE;
      end
      CMD_SLTU: begin
        alu_out.value     = {{(XLEN-1){1'b0}}, lt_unsigned};
        alu_out.lat_class = CLASS_COMPARE;
      end
      CMD_XOR: begin
        alu_out.value     = operand_a ^ operand_b;
        alu_out.lat_class = CLASS_LOGIC;
      end
      CMD_OR: begin
        alu_out.value     = operand_a | operand_b;
        alu_out.lat_class = CLASS_LOGIC;
      end
      CMD_AND: begin
        alu_out.value     = operand_a & operand_b;
        alu_out.lat_class = CLASS_LOGIC;
      end
      default: begin
        alu_out.bad_command = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/rvalu_latency_regs.sv -----
// Latency configuration registers, one per command class, with class lookup.
`timescale 1ns / 1ps

module rvalu_latency_regs
  import rvalu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LATENCY_BITS-1:0]   cfg_data,
  input  lat_class_t                lat_class,
  output logic [LATENCY_BITS-1:0]   latency
);

  logic [LATENCY_BITS-1:0] lat_reg [NUM_LAT_REGS];
  logic [LATENCY_BITS-1:0] lat_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LAT_REGS; i++) begin
        lat_reg[i] <= LATENCY_BITS'(1);
      end
    end else if (cfg_we && (32'(cfg_index) < NUM_LAT_REGS)) begin
      lat_reg[cfg_index] <= cfg_data;
    end
  end

  assign lat_raw = lat_reg[lat_class];

  // A latency register of zero is read as its reset value.
  assign latency = (lat_raw == '0) ? LATENCY_BITS'(1) : lat_raw;

endmodule

// ----- rtl/rvalu_tracker.sv -----
// Hold-and-broadcast sequencer: latency counting, held result and flush handling.
`timescale 1ns / 1ps

module rvalu_tracker
  import rvalu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  issue_item_t             item,
  input  alu_out_t                alu_out,
  input  logic [LATENCY_BITS-1:0] latency,
  output result_item_t            result
);

  logic [LATENCY_BITS-1:0] elapsed;
  logic [LATENCY_BITS-1:0] elapsed_next;
  logic [LATENCY_BITS-1:0] target;
  logic [LATENCY_BITS-1:0] target_next;
  logic [TAG_BITS-1:0]     held_tag;
  logic [XLEN-1:0]         held_value;
  logic                    capture;

  always_comb begin
    elapsed_next = elapsed;
    target_next  = target;
    capture      = 1'b0;
    result       = '0;
    if (item.flush) begin
      elapsed_next = '0;
      target_next  = '0;
    end else if (elapsed == '0) begin
      if (item.issue_valid) begin
        result.accepted = 1'b1;
        if (alu_out.bad_command) begin
          result.bad_command = 1'b1;
        end else begin
          elapsed_next = LATENCY_BITS'(1);
          target_next  = latency;
          capture      = 1'b1;
        end
      end
    end else if (elapsed < target) begin
      elapsed_next = elapsed + LATENCY_BITS'(1);
    end else begin
      result.result_valid = 1'b1;
      result.result_tag   = held_tag;
      result.result_value = held_value;
      elapsed_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      target  <= '0;
    end else if (step) begin
      elapsed <= elapsed_next;
      target  <= target_next;
    end
    if (step && capture) begin
      held_tag   <= item.rob_tag;
      held_value <= alu_out.value;
    end
  end

`ifndef SYNTH
  a_elapsed_bounded: assert property (@(posedge clk) disable iff (rst)
    (elapsed != '0) |-> (elapsed <= target))
    else $error("Elapsed count passed its target latency.");

  a_flush_idles: assert property (@(posedge clk) disable iff (rst)
    (step && item.flush) |=> (elapsed == '0 && target == '0))
    else $error("Flush did not return the unit to idle.");

  a_issue_starts: assert property (@(posedge clk) disable iff (rst)
    (step && result.accepted && !result.bad_command) |=>
      (elapsed == LATENCY_BITS'(1) && target != '0))
    else $error("Accepted operation did not start its latency count.");

  a_no_accept_on_broadcast: assert property (@(posedge clk) disable iff (rst)
    (step && result.result_valid) |=> (elapsed == '0))
    else $error("Unit stayed busy after a broadcast.");
`endif

endmodule

// ----- rtl/rv32i_alu_exec_unit.sv -----
// Top level of the RV32I integer execution unit with stream ports and configuration port.
//
//   Channel  Direction  Handshake                      Payload
//   s_axis   in         s_axis_tvalid / s_axis_tready  tdata: issue fields, tuser: command
//   m_axis   out        m_axis_tvalid / m_axis_tready  tdata: result fields
//   cfg      in         cfg_we (no wait)               cfg_index, cfg_data
//
// Every input transfer yields exactly one output transfer.
// One input transfer is taken per cycle while the output is not stalled; the input register and
// output register bound the path, with the ALU and the sequencer between them.
// Reset is synchronous; it sets all latency registers to one and the unit to idle.
// A stalled output register holds its transfer and holds the input register behind it.
`timescale 1ns / 1ps

module rv32i_alu_exec_unit
  import rvalu_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // issue_valid, operand_a, operand_b, inst_pc, rob_tag, flush
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  // command
  input  logic [CMD_BITS-1:0]       s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // accepted, result_valid, result_tag, result_value, bad_command, zero fill
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LATENCY_BITS-1:0]   cfg_data
);

  issue_item_t             in_item;
  issue_item_t             s1_item;
  logic                    s1_valid;
  result_item_t            out_item;
  logic                    out_valid;
  result_item_t            step_result;
  alu_out_t                alu_out;
  logic [LATENCY_BITS-1:0] latency;
  logic                    advance;

  assign in_item.issue_valid = s_axis_tdata[0];
  assign in_item.operand_a   = s_axis_tdata[1 +: XLEN];
  assign in_item.operand_b   = s_axis_tdata[1 + XLEN +: XLEN];
  assign in_item.inst_pc     = s_axis_tdata[1 + 2 * XLEN +: XLEN];
  assign in_item.rob_tag     = s_axis_tdata[1 + 3 * XLEN +: TAG_BITS];
  assign in_item.flush       = s_axis_tdata[1 + 3 * XLEN + TAG_BITS];
  assign in_item.command     = s_axis_tuser;

  assign advance       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (s_axis_tready && s_axis_tvalid) begin
      s1_item <= in_item;
    end
    if (advance) begin
      out_item <= step_result;
    end
  end

  rvalu_alu u_alu (
    .command   (s1_item.command),
    .operand_a (s1_item.operand_a),
    .operand_b (s1_item.operand_b),
    .inst_pc   (s1_item.inst_pc),
    .alu_out   (alu_out)
  );

  rvalu_latency_regs u_latency_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lat_class (alu_out.lat_class),
    .latency   (latency)
  );

  rvalu_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (s1_item),
    .alu_out (alu_out),
    .latency (latency),
    .result  (step_result)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, out_item.bad_command, out_item.result_value,
                          out_item.result_tag, out_item.result_valid, out_item.accepted};

endmodule

// ----- bench/tb_rv32i_alu_exec_unit.sv -----
// Self-checking testbench for the RV32I integer execution unit with a cycle-level predictor.
`timescale 1ns / 1ps

module tb_rv32i_alu_exec_unit;
  import rvalu_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 10;
  localparam int MAX_GAP       = 5;
  localparam int RANDOM_ITEMS  = 800;
  localparam int RANDOM_PHASES = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_LIMIT   = 30;

  localparam int OUT_TAG_LSB   = 2;
  localparam int OUT_VALUE_LSB = OUT_TAG_LSB + TAG_BITS;
  localparam int OUT_BAD_BIT   = OUT_VALUE_LSB + XLEN;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_SPARE = 3'd7;
  localparam logic [CMD_BITS-1:0]       CMD_ILLEGAL_LO  = 4'd12;
  localparam logic [CMD_BITS-1:0]       CMD_ILLEGAL_HI  = 4'd15;

  typedef logic [LATENCY_BITS-1:0] lat_set_t [NUM_LAT_REGS];

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic [CMD_BITS-1:0]       s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [LATENCY_BITS-1:0]   cfg_data;

  issue_item_t  offer_item;
  bit           steady;
  result_item_t pending_results [$];

  // Predictor copy of the unit.
  logic [LATENCY_BITS-1:0] lat_cfg [NUM_LAT_REGS];
  logic [LATENCY_BITS-1:0] ticks_held;
  logic [LATENCY_BITS-1:0] ticks_due;
  logic [TAG_BITS-1:0]     held_rob_tag;
  logic [XLEN-1:0]         held_result;

  int          error_count;
  int          results_checked;
  int          items_sent;
  int          ops_broadcast;
  int          illegal_taken;
  int          flushes_seen;
  int unsigned cycle_count;

  always #CLK_HALF clk = ~clk;

  // tdata fields from the lowest bit: issue_valid, operand_a, operand_b, inst_pc, rob_tag, flush.
  assign s_axis_tdata = IN_TDATA_BITS'({offer_item.flush, offer_item.rob_tag, offer_item.inst_pc,
                                        offer_item.operand_b, offer_item.operand_a,
                                        offer_item.issue_valid});
  // tuser: command.
  assign s_axis_tuser = offer_item.command;

  rv32i_alu_exec_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic void alu_compute(input issue_item_t it, output logic [XLEN-1:0] value,
                                      output lat_class_t cls, output logic legal);
    logic [SHAMT_BITS-1:0] shamt;
    shamt = it.operand_b[SHAMT_BITS-1:0];
    value = '0;
    cls   = CLASS_ADD;
    legal = 1'b1;
    case (it.command)
      CMD_ADD: begin
        value = it.operand_a + it.operand_b;
        cls   = CLASS_ADD;
      end
      CMD_SUB: begin
        value = it.operand_a - it.operand_b;
        cls   = CLASS_SUB;
      end
      CMD_LUI: begin
        value = it.operand_a;
        cls   = CLASS_LUI;
      end
      CMD_AUIPC: begin
        value = it.operand_a + it.inst_pc;
        cls   = CLASS_AUIPC;
      end
      CMD_SLL: begin
        value = it.operand_a << shamt;
        cls   = CLASS_SHIFT;
      end
      CMD_SRL: begin
        value = it.operand_a >> shamt;
        cls   = CLASS_SHIFT;
      end
      CMD_SRA: begin
        value = $signed(it.operand_a) >>> shamt;
        cls   = CLASS_SHIFT;
      end
      CMD_SLT: begin
        value = XLEN'($signed(it.operand_a) < $signed(it.operand_b));
        cls   = CLASS_COMPARE;
      end
      CMD_SLTU: begin
        value = XLEN'(it.operand_a < it.operand_b);
        cls   = CLASS_COMPARE;
      end
      CMD_XOR: begin
        value = it.operand_a ^ it.operand_b;
        cls   = CLASS_LOGIC;
      end
      CMD_OR: begin
        value = it.operand_a | it.operand_b;
        cls   = CLASS_LOGIC;
      end
      CMD_AND: begin
        value = it.operand_a & it.operand_b;
        cls   = CLASS_LOGIC;
      end
      default: begin
        legal = 1'b0;
      end
    endcase
  endfunction

  // One tick of the unit: flush first, then accept when idle, count while holding, broadcast.
  function automatic result_item_t exec_slot_tick(input issue_item_t it);
    result_item_t r;
    logic [XLEN-1:0] value;
    lat_class_t cls;
    logic legal;
    r = '0;
    if (it.flush) begin
      ticks_held = '0;
      ticks_due  = '0;
    end else if (ticks_held == '0) begin
      if (it.issue_valid) begin
        alu_compute(it, value, cls, legal);
        r.accepted = 1'b1;
        if (!legal) begin
          r.bad_command = 1'b1;
        end else begin
          ticks_due    = (lat_cfg[cls] == '0) ? LATENCY_BITS'(1) : lat_cfg[cls];
          ticks_held   = LATENCY_BITS'(1);
          held_rob_tag = it.rob_tag;
          held_result  = value;
        end
      end
    end else if (ticks_held < ticks_due) begin
      ticks_held = ticks_held + 1'b1;
    end else begin
      r.result_valid = 1'b1;
      r.result_tag   = held_rob_tag;
      r.result_value = held_result;
      ticks_held     = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [XLEN-1:0] want,
                                 input logic [XLEN-1:0] got);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("Mismatch at cycle %0d, result %0d: %s expected 0x%0h, got 0x%0h",
               cycle_count, results_checked, what, want, got);
    end
  endtask

  task automatic check_result(input logic [OUT_TDATA_BITS-1:0] word);
    result_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("transfer with nothing expected, value", '0,
                      word[OUT_VALUE_LSB +: XLEN]);
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (word[0] !== want.accepted) begin
      report_mismatch("accepted", XLEN'(want.accepted), XLEN'(word[0]));
    end
    if (word[1] !== want.result_valid) begin
      report_mismatch("result_valid", XLEN'(want.result_valid), XLEN'(word[1]));
    end
    if (word[OUT_TAG_LSB +: TAG_BITS] !== want.result_tag) begin
      report_mismatch("result_tag", XLEN'(want.result_tag), XLEN'(word[OUT_TAG_LSB +: TAG_BITS]));
    end
    if (word[OUT_VALUE_LSB +: XLEN] !== want.result_value) begin
      report_mismatch("result_value", want.result_value, word[OUT_VALUE_LSB +: XLEN]);
    end
    if (word[OUT_BAD_BIT] !== want.bad_command) begin
      report_mismatch("bad_command", XLEN'(want.bad_command), XLEN'(word[OUT_BAD_BIT]));
    end
    if (word[OUT_TDATA_BITS-1:OUT_FIELD_BITS] !== '0) begin
      report_mismatch("zero fill", '0, XLEN'(word[OUT_TDATA_BITS-1:OUT_FIELD_BITS]));
    end
  endtask

  // Predicting before checking keeps both sides of one edge in a fixed order.
  always @(posedge clk) begin
    result_item_t predicted;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = exec_slot_tick(offer_item);
        pending_results.push_back(predicted);
        if (predicted.result_valid) ops_broadcast++;
        if (predicted.bad_command) illegal_taken++;
        if (offer_item.flush) flushes_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL rv32i_alu_exec_unit");
      $finish;
    end
  end

  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Leaves tvalid high after the transfer so that a back-to-back item needs no toggle.
  task automatic send_issue(input issue_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    offer_item    <= it;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all seven latency registers, then the unused index, which must have no effect.
  task automatic load_latencies(input lat_set_t lats);
    int i;
    for (i = 0; i < NUM_LAT_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= lat_class_t'(i);
      cfg_data  <= lats[i];
      @(posedge clk);
      lat_cfg[i] = lats[i];
    end
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INDEX_SPARE;
    cfg_data  <= LATENCY_BITS'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic issue_item_t make_issue(input logic [CMD_BITS-1:0] cmd,
                                             input logic [XLEN-1:0] a, input logic [XLEN-1:0] b,
                                             input logic [XLEN-1:0] pc,
                                             input logic [TAG_BITS-1:0] tag);
    issue_item_t it;
    it.issue_valid = 1'b1;
    it.command     = cmd;
    it.operand_a   = a;
    it.operand_b   = b;
    it.inst_pc     = pc;
    it.rob_tag     = tag;
    it.flush       = 1'b0;
    return it;
  endfunction

  function automatic logic [XLEN-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic issue_item_t random_issue();
    issue_item_t it;
    it.issue_valid = ($urandom_range(0, 9) < 7);
    if ($urandom_range(0, 15) == 0) begin
      it.command = CMD_BITS'($urandom_range(CMD_ILLEGAL_LO, CMD_ILLEGAL_HI));
    end else begin
      it.command = CMD_BITS'($urandom_range(CMD_ADD, CMD_AND));
    end
    it.operand_a = pick_word();
    it.operand_b = pick_word();
    it.inst_pc   = $urandom();
    it.rob_tag   = TAG_BITS'($urandom());
    it.flush     = ($urandom_range(0, 39) == 0);
    return it;
  endfunction

  // Reset latencies of one: every operation but OR on edge operands, each followed by a busy tick.
  task automatic test_every_command();
    issue_item_t ops [11];
    int i;
    ops[0]  = make_issue(CMD_ADD,   '1,           32'd1,        32'd0,        6'd0);
    ops[1]  = make_issue(CMD_SUB,   '0,           32'd1,        '1,           6'h3F);
    ops[2]  = make_issue(CMD_LUI,   32'hABCDE000, '1,           32'd0,        6'h15);
    ops[3]  = make_issue(CMD_AUIPC, 32'hFFFFF000, 32'd0,        32'h0000_1000, 6'h2A);
    ops[4]  = make_issue(CMD_SLL,   '1,           '1,           32'd0,        6'd1);
    ops[5]  = make_issue(CMD_SLT,   32'h8000_0000, 32'h7FFF_FFFF, 32'd0,      6'd2);
    ops[6]  = make_issue(CMD_SLTU,  32'h8000_0000, 32'h7FFF_FFFF, 32'd0,      6'd3);
    ops[7]  = make_issue(CMD_XOR,   32'hAAAA_5555, '1,           32'd0,        6'd4);
    ops[8]  = make_issue(CMD_SRL,   32'h8000_0000, 32'h0000_003F, 32'd0,      6'd5);
    ops[9]  = make_issue(CMD_SRA,   32'h8000_0000, 32'd31,       32'd0,        6'd6);
    ops[10] = make_issue(CMD_AND,   '1,           32'h0F0F_0F0F, 32'd0,       6'd7);
    for (i = 0; i < 11; i++) begin
      send_issue(ops[i]);
      if (i % 2 == 0) begin
        send_issue(make_issue(CMD_ILLEGAL_HI, '1, '1, '1, '1));
      end else begin
        send_issue('0);
      end
    end
    send_issue(make_issue(CMD_ILLEGAL_LO, 32'd5, 32'd6, 32'd7, 6'd8));
    send_issue(make_issue(CMD_ILLEGAL_HI, '1, '1, '1, '1));
  endtask

  // Flush while holding, flush on the broadcast tick, and a latency register of zero.
  task automatic test_flush_and_zero_latency();
    lat_set_t lats;
    issue_item_t it;
    lats[CLASS_ADD]     = '0;
    lats[CLASS_SUB]     = '1;
    lats[CLASS_LUI]     = 4'd2;
    lats[CLASS_AUIPC]   = 4'd2;
    lats[CLASS_SHIFT]   = 4'd3;
    lats[CLASS_COMPARE] = 4'd3;
    lats[CLASS_LOGIC]   = 4'd1;
    wait_until_drained();
    load_latencies(lats);
    send_issue(make_issue(CMD_SUB, 32'd5, 32'd7, 32'd0, 6'd9));
    it = make_issue(CMD_AND, '1, '1, '1, 6'd10);
    it.flush = 1'b1;
    send_issue(it);
    send_issue(make_issue(CMD_ADD, '1, '1, 32'd0, 6'd11));
    send_issue('0);
    send_issue(make_issue(CMD_XOR, 32'h1234_5678, '1, 32'd0, 6'd12));
    it = make_issue(CMD_ADD, 32'd1, 32'd1, 32'd0, 6'd13);
    it.flush = 1'b1;
    send_issue(it);
    send_issue(make_issue(CMD_OR, 32'hF000_000F, 32'h0FF0_0FF0, 32'd0, 6'd14));
    send_issue('0);
  endtask

  task automatic test_random_phases();
    lat_set_t lats;
    int phase;
    int n;
    int k;
    int per_phase;
    per_phase = RANDOM_ITEMS / RANDOM_PHASES;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (k = 0; k < NUM_LAT_REGS; k++) begin
        case (phase)
          0: lats[k] = LATENCY_BITS'(1);
          1: lats[k] = '1;
          2: lats[k] = LATENCY_BITS'($urandom_range(0, 15));
          default: lats[k] = LATENCY_BITS'($urandom_range(1, 4));
        endcase
      end
      wait_until_drained();
      load_latencies(lats);
      for (n = 0; n < per_phase; n++) begin
        steady = (n < per_phase / 4);
        if (phase == 3 && n == per_phase / 2) wait_until_drained();
        send_issue(random_issue());
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    int i;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    offer_item    <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    steady        = 1'b0;
    for (i = 0; i < NUM_LAT_REGS; i++) lat_cfg[i] = LATENCY_BITS'(1);
    ticks_held   = '0;
    ticks_due    = '0;
    held_rob_tag = '0;
    held_result  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_every_command();
    test_flush_and_zero_latency();
    test_random_phases();

    wait_until_drained();
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", '0, XLEN'(pending_results.size()));
    end
    $display("Sent %0d issue ticks; checked %0d transfers with %0d broadcasts.",
             items_sent, results_checked, ops_broadcast);
    $display("Saw %0d illegal commands taken and %0d flushes across %0d latency settings.",
             illegal_taken, flushes_seen, RANDOM_PHASES + 1);
    if (error_count == 0) begin
      $display("PASS rv32i_alu_exec_unit");
    end else begin
      $display("FAIL rv32i_alu_exec_unit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rvalu_pkg.sv
rtl/rvalu_alu.sv
rtl/rvalu_latency_regs.sv
rtl/rvalu_tracker.sv
rtl/rv32i_alu_exec_unit.sv
bench/tb_rv32i_alu_exec_unit.sv
